// ===== hdl/phrs_pkg.sv =====
// Shared types, constants and register indexes of the plane hypothesis residual scorer.
package phrs_pkg;

  // Fraction bits of depths, sigma, log term, offset and cost.
  localparam int FRAC_BITS  = 16;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam int ACC_W      = 48;

  // Serial divider: 64-bit dividend, 32-bit divisor, two quotient bits per cycle.
  localparam int DIV_W      = 64;
  localparam int DVS_W      = 32;
  localparam int DIV_RADIX  = 2;
  localparam int DIV_STEPS  = DIV_W / DIV_RADIX;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_X     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Y     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Z     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_OFFSET = CFG_IDX_W'(3);

  localparam logic [14:0] NORMAL_Z_RST = 15'd16384;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic        [14:0] dir_z;
    logic        [23:0] point_depth;
    logic        [23:0] noise_sigma;
    logic signed [23:0] log_sigma_term;
    logic               last_point;
  } phrs_in_t;

  typedef struct packed {
    logic signed [31:0]      point_cost;
    logic                    is_inlier;
    logic signed [ACC_W-1:0] total_cost;
    logic                    last_result;
  } phrs_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_X,
    ST_MUL_Y,
    ST_MUL_Z,
    ST_MUL_D,
    ST_DIV1_SET,
    ST_DIV1,
    ST_DIV2_SET,
    ST_DIV2,
    ST_SQUARE,
    ST_COST
  } phrs_state_t;

endpackage

// ===== hdl/plane_hypothesis_residual_scorer_core.sv =====
// Top level of the plane hypothesis residual scorer: sequencer, shared multiplier and divider.
//
// The block scores a stream of depth points against one plane hypothesis.
// The plane (normal_x, normal_y, normal_z, plane_offset) is written on the
// cfg_ port, one register per request; the user must write it only while the
// block is idle, which the block does not enforce. cfg_ready is always high
// and indexes above the last register are ignored. Each point arrives as one
// request on the in_ channel and produces exactly one result request on the
// out_ channel: the point cost, an inlier flag, the running total of negative
// costs and a copy of the last-point flag. After a point flagged last the
// running total restarts from zero. For each point the shared 33x33
// multiplier forms the dot product and the numerator (ST_MUL_X to ST_MUL_D),
// then the shared radix-4 serial divider makes two passes (predicted depth,
// then the sigma-normalized residual), the multiplier forms the square and
// ST_COST forms the cost. in_ready is high only while the sequencer is idle.
// The result sits in an output register, so the next point is accepted and
// worked on while a result still waits; if the receiver stalls, the next
// point holds in its final cycle until the output register frees up.
// Reset clears the sequencer, the running total, the output valid flag and
// restores the plane registers to their reset values.
module plane_hypothesis_residual_scorer_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  phrs_pkg::phrs_in_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output phrs_pkg::phrs_out_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [phrs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [phrs_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import phrs_pkg::*;

  localparam logic signed [63:0] DIFF_LIM = 64'sd1 <<< (62 - FRAC_BITS);
  localparam logic signed [31:0] COST_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] COST_MIN = 32'sh8000_0000;
  localparam logic signed [ACC_W:0] ACC_LO = -((ACC_W+1)'(1) <<< (ACC_W - 1));

  phrs_state_t state_r, state_nxt;

  // Plane registers.
  logic signed [15:0] nx_r, ny_r;
  logic        [14:0] nz_r;
  logic signed [31:0] d_r;

  // Datapath registers.
  phrs_in_t                item_r;
  logic signed [63:0]      prod_r;
  logic signed [33:0]      dot_r;
  logic        [DIV_W-1:0] dvd_r;
  logic        [DVS_W-1:0] rem_r;
  logic        [DVS_W-1:0] dvs_r;
  logic [DIV_CNT_W-1:0]    cnt_r;
  logic                    neg_r;
  logic                    big_r;
  logic signed [ACC_W-1:0] acc_r;
  logic                    out_valid_r;
  phrs_out_t               out_data_r;

  // Combinational datapath signals.
  logic signed [32:0]      mul_a, mul_b;
  logic                    mul_en;
  logic signed [65:0]      mul_full;
  logic        [DVS_W-1:0] rem_s [0:DIV_RADIX];
  logic        [DIV_W-1:0] dvd_s [0:DIV_RADIX];
  logic        [DVS_W:0]   trial [0:DIV_RADIX-1];
  logic        [DVS_W:0]   trial_sub [0:DIV_RADIX-1];
  logic signed [33:0]      dot_fix;
  logic        [DVS_W-1:0] dot_mag;
  logic        [63:0]      num_mag;
  logic                    num_neg;
  logic signed [63:0]      pred;
  logic signed [63:0]      diff;
  logic        [63:0]      diff_mag;
  logic        [DVS_W-1:0] sigma_fix;
  logic        [63:0]      sq;
  logic signed [64:0]      cost_sum;
  logic signed [31:0]      cost;
  logic signed [ACC_W:0]   acc_sum;
  logic signed [ACC_W-1:0] acc_after;
  logic                    commit;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = ST_MUL_X;
      ST_MUL_X:    state_nxt = ST_MUL_Y;
      ST_MUL_Y:    state_nxt = ST_MUL_Z;
      ST_MUL_Z:    state_nxt = ST_MUL_D;
      ST_MUL_D:    state_nxt = ST_DIV1_SET;
      ST_DIV1_SET: state_nxt = ST_DIV1;
      ST_DIV1:     if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) state_nxt = ST_DIV2_SET;
      ST_DIV2_SET: state_nxt = ST_DIV2;
      ST_DIV2:     if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) state_nxt = ST_SQUARE;
      ST_SQUARE:   state_nxt = ST_COST;
      ST_COST:     if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Datapath control and arithmetic.
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (state_r)
      ST_MUL_X: begin
        mul_a = {{17{nx_r[15]}}, nx_r};
        mul_b = {{17{item_r.dir_x[15]}}, item_r.dir_x};
      end
      ST_MUL_Y: begin
        mul_a = {{17{ny_r[15]}}, ny_r};
        mul_b = {{17{item_r.dir_y[15]}}, item_r.dir_y};
      end
      ST_MUL_Z: begin
        mul_a = {18'b0, nz_r};
        mul_b = {18'b0, item_r.dir_z};
      end
      ST_MUL_D: begin
        mul_a = {d_r[31], d_r};
        mul_b = {18'b0, item_r.dir_z};
      end
      ST_SQUARE: begin
        mul_a = {1'b0, dvd_r[31:0]};
        mul_b = {1'b0, dvd_r[31:0]};
      end
      default: mul_en = 1'b0;
    endcase
    mul_full = mul_a * mul_b;

    // Two restoring division steps per cycle.
    rem_s[0] = rem_r;
    dvd_s[0] = dvd_r;
    for (int k = 0; k < DIV_RADIX; k++) begin
      trial[k]     = {rem_s[k], dvd_s[k][DIV_W-1]};
      trial_sub[k] = trial[k] - {1'b0, dvs_r};
      if (trial[k] >= {1'b0, dvs_r}) begin
        rem_s[k+1] = trial_sub[k][DVS_W-1:0];
        dvd_s[k+1] = {dvd_s[k][DIV_W-2:0], 1'b1};
      end else begin
        rem_s[k+1] = trial[k][DVS_W-1:0];
        dvd_s[k+1] = {dvd_s[k][DIV_W-2:0], 1'b0};
      end
    end

    // Predicted depth division setup; a zero dot product counts as one LSB.
    dot_fix = (dot_r == 34'sd0) ? 34'sd1 : dot_r;
    dot_mag = dot_fix[33] ? DVS_W'(-dot_fix) : DVS_W'(dot_fix);
    num_mag = (prod_r[63] ? 64'(-prod_r) : 64'(prod_r)) << 14;
    num_neg = (prod_r > 64'sd0);

    // Residual division setup.
    pred = neg_r ? -$signed(dvd_r) : $signed(dvd_r);
    diff = pred - $signed({40'b0, item_r.point_depth});
    if (diff > DIFF_LIM) diff = DIFF_LIM;
    if (diff < -DIFF_LIM) diff = -DIFF_LIM;
    diff_mag  = diff[63] ? 64'(-diff) : 64'(diff);
    sigma_fix = (item_r.noise_sigma == 24'd0) ? DVS_W'(1) : DVS_W'(item_r.noise_sigma);

    // Cost and running total.
    sq       = $unsigned(prod_r) >> (FRAC_BITS + 1);
    cost_sum = $signed({1'b0, sq})
             + $signed({{41{item_r.log_sigma_term[23]}}, item_r.log_sigma_term});
    if (big_r || cost_sum > 65'(COST_MAX)) begin
      cost = COST_MAX;
    end else if (cost_sum < 65'(COST_MIN)) begin
      cost = COST_MIN;
    end else begin
      cost = cost_sum[31:0];
    end
    acc_sum = $signed({acc_r[ACC_W-1], acc_r}) + $signed({{(ACC_W-31){cost[31]}}, cost});
    if (!cost[31]) begin
      acc_after = acc_r;
    end else if (acc_sum < ACC_LO) begin
      acc_after = ACC_LO[ACC_W-1:0];
    end else begin
      acc_after = acc_sum[ACC_W-1:0];
    end
    commit = (state_r == ST_COST) && (!out_valid_r || out_ready);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      nx_r        <= '0;
      ny_r        <= '0;
      nz_r        <= NORMAL_Z_RST;
      d_r         <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_NORMAL_X:     nx_r <= cfg_data[15:0];
          REG_NORMAL_Y:     ny_r <= cfg_data[15:0];
          REG_NORMAL_Z:     nz_r <= cfg_data[14:0];
          REG_PLANE_OFFSET: d_r  <= cfg_data[31:0];
          default: ;
        endcase
      end
      if (state_r inside {ST_DIV1, ST_DIV2}) begin
        cnt_r <= cnt_r + DIV_CNT_W'(1);
      end else begin
        cnt_r <= '0;
      end
      if (commit) begin
        acc_r       <= item_r.last_point ? '0 : acc_after;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    if (mul_en) begin
      prod_r <= mul_full[63:0];
    end
    case (state_r)
      ST_MUL_Y: dot_r <= prod_r[33:0];
      ST_MUL_Z: dot_r <= dot_r + prod_r[33:0];
      ST_MUL_D: dot_r <= dot_r + prod_r[33:0];
      ST_DIV1_SET: begin
        dvd_r <= num_mag;
        dvs_r <= dot_mag;
        rem_r <= '0;
        neg_r <= num_neg != dot_fix[33];
      end
      ST_DIV2_SET: begin
        dvd_r <= diff_mag << FRAC_BITS;
        dvs_r <= sigma_fix;
        rem_r <= '0;
      end
      ST_DIV1, ST_DIV2: begin
        dvd_r <= dvd_s[DIV_RADIX];
        rem_r <= rem_s[DIV_RADIX];
      end
      ST_SQUARE: big_r <= |dvd_r[63:32];
      default: ;
    endcase
    if (commit) begin
      out_data_r.point_cost  <= cost;
      out_data_r.is_inlier   <= cost[31];
      out_data_r.total_cost  <= acc_after;
      out_data_r.last_result <= item_r.last_point;
    end
  end

endmodule

// ===== dv/plane_hypothesis_residual_scorer_core_tb.sv =====
// Self-checking testbench for the plane hypothesis residual scorer core.
`timescale 1ns / 1ps

module testbench;
  import phrs_pkg::*;

  localparam int RESET_CYCLES     = 4;
  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int DRAIN_CYCLES     = 150;
  localparam int RANDOM_PHASES    = 15;
  localparam int POINTS_PER_PHASE = 100;
  localparam int NOISE_PCT        = 15;

  // One unit of a Q2.14 direction component.
  localparam longint DIR_ONE   = longint'(1) << 14;
  localparam longint DEPTH_MAX = (longint'(1) << 24) - 1;
  localparam longint DIFF_LIM  = longint'(1) << (62 - FRAC_BITS);
  localparam longint COST_MAX  = (longint'(1) << 31) - 1;
  localparam longint COST_MIN  = -(longint'(1) << 31);
  localparam longint TOTAL_MIN = -(longint'(1) << (ACC_W - 1));
  localparam logic [63:0] RESIDUAL_HUGE = 64'h1_0000_0000;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  phrs_in_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  phrs_out_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Our own copy of the plane registers and of the running total of negative costs.
  logic signed [15:0] plane_nx = '0;
  logic signed [15:0] plane_ny = '0;
  logic        [14:0] plane_nz = NORMAL_Z_RST;
  logic signed [31:0] plane_d  = '0;
  longint             neg_cost_total = 0;

  phrs_in_t  pending_points[$];
  phrs_out_t expected_results[$];

  int points_open   = 0;
  int mismatches    = 0;
  int idle_cycles   = 0;
  int in_gap_pct    = 0;
  int out_stall_pct = 0;
  int in_gap_left   = 0;
  int out_stall_left = 0;
  bit in_taken      = 1'b0;

  plane_hypothesis_residual_scorer_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] magnitude(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // Depth at which the ray meets the plane, exact truncated quotient. A zero
  // denominator counts as one LSB.
  function automatic longint plane_depth(phrs_in_t p);
    longint      dot;
    longint      num;
    logic [63:0] quot;
    dot = longint'(plane_nx) * longint'($signed(p.dir_x))
        + longint'(plane_ny) * longint'($signed(p.dir_y))
        + longint'(plane_nz) * longint'(p.dir_z);
    if (dot == 0) dot = 1;
    num  = -longint'(plane_d) * longint'(p.dir_z) * DIR_ONE;
    quot = magnitude(num) / magnitude(dot);
    return ((num < 0) != (dot < 0)) ? -longint'(quot) : longint'(quot);
  endfunction

  // Cost of one point and the running total it leaves behind.
  function automatic phrs_out_t score_point(phrs_in_t p);
    phrs_out_t   res;
    longint      diff;
    longint      cost;
    logic [63:0] sigma;
    logic [63:0] resid;
    logic [63:0] square;
    diff = plane_depth(p) - longint'(p.point_depth);
    if (diff > DIFF_LIM) diff = DIFF_LIM;
    if (diff < -DIFF_LIM) diff = -DIFF_LIM;
    // A zero sigma is read as one LSB.
    sigma = (p.noise_sigma == '0) ? 64'd1 : 64'(p.noise_sigma);
    resid = (magnitude(diff) << FRAC_BITS) / sigma;
    if (resid >= RESIDUAL_HUGE) begin
      cost = COST_MAX;
    end else begin
      square = (resid * resid) >> (FRAC_BITS + 1);
      cost   = longint'(square) + longint'($signed(p.log_sigma_term));
      if (cost > COST_MAX) cost = COST_MAX;
      if (cost < COST_MIN) cost = COST_MIN;
    end
    if (cost < 0) begin
      neg_cost_total += cost;
      if (neg_cost_total < TOTAL_MIN) neg_cost_total = TOTAL_MIN;
    end
    res.point_cost  = 32'(cost);
    res.is_inlier   = (cost < 0);
    res.total_cost  = ACC_W'(neg_cost_total);
    res.last_result = p.last_point;
    if (p.last_point) neg_cost_total = 0;
    return res;
  endfunction

  function automatic phrs_in_t random_point();
    logic [127:0] raw;
    raw = {$urandom(), $urandom(), $urandom(), $urandom()};
    return raw[$bits(phrs_in_t)-1:0];
  endfunction

  function automatic phrs_in_t make_point(int dx, int dy, int dz, int depth, int sigma,
                                          int logt, bit last);
    phrs_in_t p;
    p.dir_x          = 16'(dx);
    p.dir_y          = 16'(dy);
    p.dir_z          = 15'(dz);
    p.point_depth    = 24'(depth);
    p.noise_sigma    = 24'(sigma);
    p.log_sigma_term = 24'(logt);
    p.last_point     = last;
    return p;
  endfunction

  task automatic check_field(string field, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  task automatic queue_point(phrs_in_t p);
    pending_points.push_back(p);
    points_open++;
  endtask

  // Returns once every queued point has produced its result, so the block is idle.
  task automatic wait_idle();
    while (points_open != 0) @(posedge clk);
  endtask

  // One register write request; the bits above the register width are random.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value,
                           int width);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= (CFG_DATA_W'($urandom()) << width)
               | (value & ~({CFG_DATA_W{1'b1}} << width));
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Writes the selected plane registers back to back and, if asked, one request
  // to an index past the last register, which the block must ignore.
  task automatic program_plane(logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
                               logic [31:0] d, logic [3:0] which, bit junk);
    if (which[0]) write_reg(REG_NORMAL_X, nx, 16);
    if (which[1]) write_reg(REG_NORMAL_Y, ny, 16);
    if (which[2]) write_reg(REG_NORMAL_Z, nz, 15);
    if (which[3]) write_reg(REG_PLANE_OFFSET, d, 32);
    if (junk)
      write_reg(CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, REG_PLANE_OFFSET + 1)),
                $urandom(), 32);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Driver: all inputs change on the falling edge. A point request stays up with
  // a stable payload until it is taken; idle bursts are inserted at random before
  // a new point, and the receiver stalls the same way.
  always @(negedge clk) begin : driver
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (in_gap_left > 0) begin
          in_gap_left--;
          in_valid <= 1'b0;
        end else if (pending_points.size() != 0 && $urandom_range(99) < in_gap_pct) begin
          // This cycle is the first of the burst.
          in_gap_left = $urandom_range(15, 0);
          in_valid <= 1'b0;
        end else if (pending_points.size() != 0) begin
          in_data  <= pending_points.pop_front();
          in_valid <= 1'b1;
        end else
          in_valid <= 1'b0;
      end
      if (out_stall_left > 0) begin
        out_stall_left--;
        out_ready <= 1'b0;
      end else if ($urandom_range(99) < out_stall_pct) begin
        out_stall_left = $urandom_range(15, 0);
        out_ready <= 1'b0;
      end else
        out_ready <= 1'b1;
    end
  end

  // Monitor: everything is sampled on the rising edge. Register writes update our
  // plane copy, each accepted point is scored at once, and each result request is
  // compared with the oldest score waiting. A watchdog ends the run when nothing
  // is accepted on any channel for too long.
  always @(posedge clk) begin : monitor
    phrs_out_t want;
    bit        progress;
    if (!rst_n) begin
      in_taken    = 1'b0;
      idle_cycles = 0;
    end else begin
      in_taken = in_valid && in_ready;
      progress = in_taken;
      if (cfg_valid && cfg_ready) begin
        progress = 1'b1;
        case (cfg_index)
          REG_NORMAL_X:     plane_nx = cfg_data[15:0];
          REG_NORMAL_Y:     plane_ny = cfg_data[15:0];
          REG_NORMAL_Z:     plane_nz = cfg_data[14:0];
          REG_PLANE_OFFSET: plane_d  = cfg_data[31:0];
          default: ;
        endcase
      end
      if (in_taken) expected_results.push_back(score_point(in_data));
      if (out_valid && out_ready) begin
        progress = 1'b1;
        points_open--;
        if (expected_results.size() == 0) begin
          $display("%0t: result with no point pending, expected none actual cost %0d",
                   $time, out_data.point_cost);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("point_cost", longint'(want.point_cost), longint'(out_data.point_cost));
          check_field("is_inlier", longint'(want.is_inlier), longint'(out_data.is_inlier));
          check_field("total_cost", longint'(want.total_cost), longint'(out_data.total_cost));
          check_field("last_result", longint'(want.last_result),
                      longint'(out_data.last_result));
        end
      end
      idle_cycles = progress ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no request accepted for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("plane_hypothesis_residual_scorer_core: mismatch");
        $finish;
      end
    end
  end

  initial begin : stimulus
    phrs_in_t p;
    longint   target;
    longint   spread;
    int       hyp_len;
    int       queued;
    bit       quiet;
    in_gap_pct    = 20;
    out_stall_pct = 20;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed points on the reset plane (normal straight along z, zero offset).
    // A ray with no direction gives a zero denominator, and a zero sigma is used.
    queue_point(make_point(0, 0, 0, 0, 0, -8388608, 1'b0));
    queue_point(make_point(0, 0, 16384, 24'hFFFFFF, 1, 0, 1'b0));
    queue_point(make_point(0, 0, 16384, 0, 24'hFFFFFF, 8388607, 1'b0));
    queue_point(make_point(-32768, 32767, 32767, 12345, 65536, -100000, 1'b1));
    wait_idle();

    // Extreme register patterns, normal_z past one, plus an ignored index.
    program_plane(32'h8000, 32'h7FFF, 32'h7FFF, 32'h7FFF_FFFF, 4'b1111, 1'b1);
    // Exact zero denominator with the largest numerator: the depth difference clamps.
    queue_point(make_point(32767, 1, 32767, 0, 1, 0, 1'b0));
    queue_point(make_point(1, 0, 1, 1000, 24'hFFFFFF, -1, 1'b0));
    queue_point(make_point(32767, 32767, 32767, 24'hFFFFFF, 24'hFFFFFF, 8388607, 1'b0));
    queue_point(make_point(0, 0, 0, 24'h800000, 24'h000100, -8388608, 1'b1));
    wait_idle();

    // Zero normal and the most negative offset: every denominator is zero.
    program_plane(32'h0, 32'h0, 32'h0, 32'h8000_0000, 4'b1111, 1'b0);
    queue_point(make_point(-32768, -32768, 32767, 0, 24'hFFFFFF, 0, 1'b0));
    queue_point(make_point(5, -5, 0, 65536, 65536, -65536, 1'b0));
    // Residual just below and exactly at the point where the cost saturates outright.
    queue_point(make_point(0, 0, 0, 65535, 1, -8388608, 1'b0));
    queue_point(make_point(0, 0, 0, 65536, 1, -8388608, 1'b0));
    // Square term of exactly 2^31: the log term decides between max and saturation.
    queue_point(make_point(0, 0, 0, 256, 1, -1, 1'b0));
    queue_point(make_point(0, 0, 0, 256, 1, 0, 1'b1));
    wait_idle();

    // A plausible plane ten meters away.
    program_plane(32'h4000, 32'hC000, 32'h4000, 32'(-655360), 4'b1111, 1'b1);
    queue_point(make_point(0, 5000, 5000, 655360, 65536, 0, 1'b0));
    queue_point(make_point(0, 0, 16384, 655460, 65536, -65536, 1'b0));
    queue_point(make_point(2000, -1000, 16000, 600000, 4096, -200000, 1'b1));
    queue_point(make_point(-16384, 16384, 0, 1, 24'hFFFFFF, -8388608, 1'b1));

    // Random phases, each of which may reprogram the plane registers. Most points
    // form hypotheses of plausible points near the plane with the last one
    // flagged; the rest are raw bit patterns with a random last flag.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      quiet         = (phase == RANDOM_PHASES - 1);
      in_gap_pct    = quiet ? 0 : 20 * int'($urandom_range(3));
      out_stall_pct = quiet ? 0 : 20 * int'($urandom_range(3));
      if ($urandom_range(4) == 0)
        program_plane($urandom(), $urandom(), $urandom(), $urandom(), 4'($urandom()),
                      1'($urandom_range(1)));
      else
        program_plane(32'(int'($urandom_range(12000)) - 6000),
                      32'(int'($urandom_range(12000)) - 6000),
                      32'($urandom_range(16384, 10000)),
                      32'(-int'($urandom_range(200 << 16, 1 << 14))),
                      ($urandom_range(3) == 0) ? 4'b1000 : 4'b1111,
                      1'($urandom_range(3) == 0));
      queued = 0;
      while (queued < POINTS_PER_PHASE) begin
        hyp_len = $urandom_range(24, 1);
        for (int k = 0; k < hyp_len; k++) begin
          p = random_point();
          if ($urandom_range(99) >= NOISE_PCT) begin
            p.dir_x       = 16'(int'($urandom_range(12000)) - 6000);
            p.dir_y       = 16'(int'($urandom_range(12000)) - 6000);
            p.dir_z       = 15'($urandom_range(16384, 9000));
            p.noise_sigma = 24'($urandom_range(1 << 18, 1 << 10));
            // Measured depth lands within a few sigma of the plane.
            spread = longint'(p.noise_sigma) * (($urandom_range(3) == 0) ? 8 : 2);
            target = plane_depth(p) + longint'($urandom_range(32'(2 * spread))) - spread;
            if (target < 0) target = 0;
            if (target > DEPTH_MAX) target = DEPTH_MAX;
            p.point_depth    = 24'(target);
            p.log_sigma_term = 24'(int'($urandom_range(5 << 16)) - (4 << 16));
            p.last_point     = (k == hyp_len - 1);
          end
          queue_point(p);
          queued++;
        end
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("plane_hypothesis_residual_scorer_core: match");
    else
      $display("plane_hypothesis_residual_scorer_core: mismatch");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/phrs_pkg.sv
hdl/plane_hypothesis_residual_scorer_core.sv
dv/plane_hypothesis_residual_scorer_core_tb.sv
